FILE: hw/rtl/mat_pkg.sv
// shared constants, register codes and the gray conversion for the median threshold core
package mat_pkg;

   // default geometry
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 4096;
   localparam int DEF_RADIUS     = 2;

   // field widths
   localparam int PIX_W          = 8;
   localparam int REGION_WIDTH_W = 11;
   localparam int REGION_HEIGHT_W = 13;
   localparam int CSR_DATA_W     = 13;
   localparam int CSR_INDEX_W    = 1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_REGION_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_REGION_HEIGHT = 1'd1;

   // gray weights, sum of 3r+6g+b fits in 12 bits
   localparam int GRAY_R     = 3;
   localparam int GRAY_G     = 6;
   localparam int GRAY_B     = 1;
   localparam int SUM_W      = 12;
   // divide by ten as multiply by ceil(2^16/10) and shift, exact for sums up to 2550
   localparam int GRAY_MUL   = 6554;
   localparam int GRAY_SHIFT = 16;
   localparam int MUL_W      = 26;

   // weighted sum of one rgb pixel
   function automatic logic [SUM_W-1:0] gray_sum(input logic [PIX_W-1:0] r,
                                                 input logic [PIX_W-1:0] g,
                                                 input logic [PIX_W-1:0] b);
      gray_sum = SUM_W'(r) * SUM_W'(GRAY_R) + SUM_W'(g) * SUM_W'(GRAY_G)
               + SUM_W'(b) * SUM_W'(GRAY_B);
   endfunction

   // sum divided by ten, truncated
   function automatic logic [PIX_W-1:0] gray_div(input logic [SUM_W-1:0] s);
      logic [MUL_W-1:0] p;
      p = MUL_W'(s) * MUL_W'(GRAY_MUL);
      gray_div = PIX_W'(p >> GRAY_SHIFT);
   endfunction

endpackage

FILE: hw/rtl/mat_req_if.sv
// request channel: one rgb pixel or a drain marker
interface mat_req_if import mat_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] red;
   logic [PIX_W-1:0] green;
   logic [PIX_W-1:0] blue;
   logic             drain;

   modport source (output valid, red, green, blue, drain, input ready);
   modport sink   (input valid, red, green, blue, drain, output ready);
endinterface

FILE: hw/rtl/mat_rsp_if.sv
// response channel: thresholded level and frame end flag
interface mat_rsp_if import mat_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] level;
   logic             frame_end;

   modport source (output valid, level, frame_end, input ready);
   modport sink   (input valid, level, frame_end, output ready);
endinterface

FILE: hw/rtl/mat_cell.sv
// one window column cell: holds a vertical column of gray values and hands it on
module mat_cell import mat_pkg::*; #(
   parameter int SIDE = 2 * DEF_RADIUS + 1
) (
   input  logic                       clock,
   input  logic                       shift,
   input  logic [SIDE-1:0][PIX_W-1:0] col_in,
   output logic [SIDE-1:0][PIX_W-1:0] col_ff
);

   // take the neighbor's column whenever the chain advances
   always_ff @(posedge clock) begin
      if (shift) begin
         col_ff <= col_in;
      end
   end

endmodule

FILE: hw/rtl/mat_rank.sv
// rank selection over the window: compare matrix, then rank count and pick
module mat_rank import mat_pkg::*; #(
   parameter  int RADIUS = DEF_RADIUS,
   localparam int SIDE   = 2 * RADIUS + 1,
   localparam int N      = SIDE * SIDE,
   localparam int HFW    = $clog2(N)
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic [N-1:0][PIX_W-1:0] vals,
   input  logic [N-1:0]            vmask,
   input  logic [HFW-1:0]          half,
   output logic [PIX_W-1:0]        median_ff
);

   logic [N-1:0][N-1:0]     cmp_in;
   logic [N-1:0][N-1:0]     cmp_ff;
   logic [N-1:0][PIX_W-1:0] vals_ff;
   logic [N-1:0]            vmask_ff;
   logic [HFW-1:0]          half_ff;
   logic [PIX_W-1:0]        median_in;

   // j counts below i when smaller, or equal and earlier (ties broken by position)
   always_comb begin
      for (int i = 0; i < N; i++) begin
         for (int j = 0; j < N; j++) begin
            cmp_in[i][j] = (i != j) && vmask[j] &&
                           ((vals[j] < vals[i]) || ((vals[j] == vals[i]) && (j < i)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cmp_ff   <= cmp_in;
         vals_ff  <= vals;
         vmask_ff <= vmask;
         half_ff  <= half;
      end
   end

   // the valid entry whose rank equals half is the median
   always_comb begin
      median_in = '0;
      for (int i = 0; i < N; i++) begin
         if (vmask_ff[i] && (HFW'($countones(cmp_ff[i])) == half_ff)) begin
            median_in = median_in | vals_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         median_ff <= median_in;
      end
   end

endmodule

FILE: hw/rtl/median_adaptive_threshold_core.sv
// Local median adaptive threshold over a (2*RADIUS+1)^2 window on an RGB raster stream.
// Each request carries one pixel (or a drain marker); the core converts it to gray,
// keeps 2*RADIUS previous rows in a column-addressed line memory and shifts the window
// through a chain of column cells. One request is taken per clock whenever the response
// register is free or being read, so the sustained rate is one item per cycle. A response
// for pixel q appears once request q + RADIUS*width + RADIUS has been taken; after the
// last pixel send that many drain requests to flush the frame. The pipeline from the
// triggering request to the response register runs through the memory read, column chain,
// compare matrix, rank select and threshold registers. Drains before the last pixel are
// taken and dropped. A register write restarts the frame counters; the line memory needs
// no clearing pass since stale entries are always masked by the window bounds.
module median_adaptive_threshold_core import mat_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int RADIUS     = DEF_RADIUS
) (
   input  logic                   clock,
   input  logic                   reset,
   mat_req_if.sink                req_chan,
   mat_rsp_if.source              rsp_chan,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int SIDE = 2 * RADIUS + 1;
   localparam int N    = SIDE * SIDE;
   localparam int HIST = 2 * RADIUS;
   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int RW   = $clog2(MAX_HEIGHT);
   localparam int WRW  = $clog2(MAX_WIDTH + 1);
   localparam int HRW  = $clog2(MAX_HEIGHT + 1);
   localparam int LW   = $clog2(RADIUS * MAX_WIDTH + RADIUS + 1);
   localparam int NW   = $clog2(N + 1);
   localparam int HFW  = $clog2(N);
   localparam int CTR  = RADIUS * SIDE + RADIUS;

   typedef struct packed {
      logic             emit;
      logic             last;
      logic [PIX_W-1:0] center;
   } ctl_type;

   // configuration and frame counters
   logic [WRW-1:0] w_ff, w_in;
   logic [HRW-1:0] h_ff, h_in;
   logic [CW-1:0]  pcol_ff, pcol_in;
   logic [HRW-1:0] in_row_ff, in_row_in;
   logic [LW-1:0]  pend_ff, pend_in;
   logic [CW-1:0]  ocol_ff, ocol_in;
   logic [RW-1:0]  orow_ff, orow_in;

   logic [REGION_WIDTH_W-1:0]  wv;
   logic [REGION_HEIGHT_W-1:0] hv;
   logic [WRW-1:0] w_sat;
   logic [HRW-1:0] h_sat;
   logic [LW-1:0]  lag;
   logic en, acc, is_pix, adv, emit, last_out, pcol_wrap, ocol_wrap;

   // stage 1: line memory read and gray conversion
   logic                     s1_valid_ff;
   logic [SUM_W-1:0]         s1_sum_ff;
   logic [CW-1:0]            s1_col_ff;
   logic                     s1_emit_ff;
   logic                     s1_last_ff;
   logic [CW-1:0]            s1_ocol_ff;
   logic [RW-1:0]            s1_orow_ff;
   logic [HIST*PIX_W-1:0]    rd_ff;
   logic [HIST*PIX_W-1:0]    wr_word;
   logic [PIX_W-1:0]         gray;
   logic [SIDE-1:0][PIX_W-1:0] col_new;
   logic [SIDE-1:0]          rowm, colm;
   logic [NW-1:0]            n_valid;
   logic [N-1:0]             vmask_in;

   logic [HIST*PIX_W-1:0] mem [MAX_WIDTH];

   // stage 2 and beyond
   logic [SIDE-1:0][PIX_W-1:0] cols [SIDE];
   logic [N-1:0][PIX_W-1:0]    win;
   logic [N-1:0]               s2_vmask_ff;
   logic [HFW-1:0]             s2_half_ff;
   logic                       s2_emit_ff;
   logic                       s2_last_ff;
   ctl_type                    s3_ff, s4_ff;
   logic [PIX_W-1:0]           median;
   logic                       rsp_valid_ff;
   logic [PIX_W-1:0]           level_ff;
   logic                       frame_end_ff;

   // handshake: everything advances when the response register can take a value
   assign en             = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = en;
   assign acc            = req_chan.valid && en;
   assign is_pix         = in_row_ff < h_ff;
   assign adv            = acc && !(is_pix && req_chan.drain);
   assign lag            = LW'(w_ff) * LW'(RADIUS) + LW'(RADIUS);
   assign emit           = pend_ff == lag;
   assign pcol_wrap      = pcol_ff == CW'(w_ff - 1'b1);
   assign ocol_wrap      = ocol_ff == CW'(w_ff - 1'b1);
   assign last_out       = ocol_wrap && (orow_ff == RW'(h_ff - 1'b1));

   // saturate register writes into the legal range
   always_comb begin
      wv = csr_wdata[REGION_WIDTH_W-1:0];
      hv = csr_wdata[REGION_HEIGHT_W-1:0];
      if (wv == '0) begin
         w_sat = WRW'(1);
      end else if (32'(wv) > MAX_WIDTH) begin
         w_sat = WRW'(MAX_WIDTH);
      end else begin
         w_sat = WRW'(wv);
      end
      if (hv == '0) begin
         h_sat = HRW'(1);
      end else if (32'(hv) > MAX_HEIGHT) begin
         h_sat = HRW'(MAX_HEIGHT);
      end else begin
         h_sat = HRW'(hv);
      end
   end

   // next values of registers and counters
   always_comb begin
      w_in      = w_ff;
      h_in      = h_ff;
      pcol_in   = pcol_ff;
      in_row_in = in_row_ff;
      pend_in   = pend_ff;
      ocol_in   = ocol_ff;
      orow_in   = orow_ff;
      if (csr_write) begin
         case (csr_index)
            REG_REGION_WIDTH:  w_in = w_sat;
            REG_REGION_HEIGHT: h_in = h_sat;
            default:           w_in = w_ff;
         endcase
         pcol_in   = '0;
         in_row_in = '0;
         pend_in   = '0;
         ocol_in   = '0;
         orow_in   = '0;
      end else if (adv) begin
         if (emit && last_out) begin
            pcol_in   = '0;
            in_row_in = '0;
            pend_in   = '0;
            ocol_in   = '0;
            orow_in   = '0;
         end else begin
            pcol_in = pcol_wrap ? '0 : pcol_ff + 1'b1;
            if (pcol_wrap && is_pix) begin
               in_row_in = in_row_ff + 1'b1;
            end
            if (!emit) begin
               pend_in = pend_ff + 1'b1;
            end else begin
               ocol_in = ocol_wrap ? '0 : ocol_ff + 1'b1;
               if (ocol_wrap) begin
                  orow_in = orow_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff      <= WRW'(MAX_WIDTH);
         h_ff      <= HRW'(MAX_HEIGHT);
         pcol_ff   <= '0;
         in_row_ff <= '0;
         pend_ff   <= '0;
         ocol_ff   <= '0;
         orow_ff   <= '0;
      end else begin
         w_ff      <= w_in;
         h_ff      <= h_in;
         pcol_ff   <= pcol_in;
         in_row_ff <= in_row_in;
         pend_ff   <= pend_in;
         ocol_ff   <= ocol_in;
         orow_ff   <= orow_in;
      end
   end

   // stage 1 capture of the request
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= adv;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_sum_ff  <= (is_pix && !req_chan.drain) ?
                       gray_sum(req_chan.red, req_chan.green, req_chan.blue) : '0;
         s1_col_ff  <= pcol_ff;
         s1_emit_ff <= emit;
         s1_last_ff <= emit && last_out;
         s1_ocol_ff <= ocol_ff;
         s1_orow_ff <= orow_ff;
      end
   end

   // new column and updated row history
   assign gray    = gray_div(s1_sum_ff);
   assign wr_word = {rd_ff[(HIST-1)*PIX_W-1:0], gray};

   always_comb begin
      col_new[0] = gray;
      for (int r = 1; r < SIDE; r++) begin
         col_new[r] = rd_ff[(r-1)*PIX_W +: PIX_W];
      end
   end

   // line memory, forwarding the word being written to a same-column read
   always_ff @(posedge clock) begin
      if (en && s1_valid_ff) begin
         mem[s1_col_ff] <= wr_word;
      end
      if (adv) begin
         rd_ff <= (s1_valid_ff && (s1_col_ff == pcol_ff)) ? wr_word : mem[pcol_ff];
      end
   end

   // window bounds: rows and columns of the neighborhood that lie inside the rectangle
   always_comb begin
      for (int r = 0; r < SIDE; r++) begin
         rowm[r] = (32'(s1_orow_ff) + 32'(RADIUS) >= 32'(r)) &&
                   (32'(s1_orow_ff) + 32'(RADIUS) - 32'(r) < 32'(h_ff));
         colm[r] = (32'(s1_ocol_ff) + 32'(RADIUS) >= 32'(r)) &&
                   (32'(s1_ocol_ff) + 32'(RADIUS) - 32'(r) < 32'(w_ff));
      end
      for (int r = 0; r < SIDE; r++) begin
         for (int k = 0; k < SIDE; k++) begin
            vmask_in[r*SIDE+k] = rowm[r] && colm[k];
         end
      end
      n_valid = NW'($countones(rowm)) * NW'($countones(colm));
   end

   // column cell chain, cell k holds the column k items back
   for (genvar k = 0; k < SIDE; k++) begin : g_chain
      if (k == 0) begin : g_head
         mat_cell #(.SIDE(SIDE)) u_cell (
            .clock  (clock),
            .shift  (en && s1_valid_ff),
            .col_in (col_new),
            .col_ff (cols[k])
         );
      end else begin : g_body
         mat_cell #(.SIDE(SIDE)) u_cell (
            .clock  (clock),
            .shift  (en && s1_valid_ff),
            .col_in (cols[k-1]),
            .col_ff (cols[k])
         );
      end
   end

   always_comb begin
      for (int r = 0; r < SIDE; r++) begin
         for (int k = 0; k < SIDE; k++) begin
            win[r*SIDE+k] = cols[k][r];
         end
      end
   end

   // stage 2 control, aligned with the chain
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_emit_ff <= 1'b0;
      end else if (en) begin
         s2_emit_ff <= s1_valid_ff && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en && s1_valid_ff) begin
         s2_vmask_ff <= vmask_in;
         s2_half_ff  <= HFW'(n_valid >> 1);
         s2_last_ff  <= s1_last_ff;
      end
   end

   mat_rank #(.RADIUS(RADIUS)) u_rank (
      .clock     (clock),
      .en        (en),
      .vals      (win),
      .vmask     (s2_vmask_ff),
      .half      (s2_half_ff),
      .median_ff (median)
   );

   // control alongside the rank stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ff <= '0;
         s4_ff <= '0;
      end else if (en) begin
         s3_ff <= '{emit: s2_emit_ff, last: s2_last_ff, center: win[CTR]};
         s4_ff <= s3_ff;
      end
   end

   // response register with threshold
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= s4_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         level_ff     <= (s4_ff.center < median) ? '0 : s4_ff.center;
         frame_end_ff <= s4_ff.last;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.level     = level_ff;
   assign rsp_chan.frame_end = frame_end_ff;

endmodule

FILE: hw/rtl/mat_checker.sv
// port checks for the median threshold core and their binding
module mat_checker import mat_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [PIX_W-1:0] rsp_level,
   input logic             rsp_frame_end
);

   // a stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a stalled response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_level) && $stable(rsp_frame_end))
      else $error("response payload changed while stalled");

   // the request side is never blocked while the response side drains
   a_ready_flow: assert property (@(posedge clock)
      rsp_ready |-> req_ready)
      else $error("request blocked while response taken");

   // no response in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response offered right after reset");

endmodule

bind median_adaptive_threshold_core mat_checker u_mat_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_level     (rsp_chan.level),
   .rsp_frame_end (rsp_chan.frame_end)
);
